>>> rtl/gregorian_date_add_days_assert.svh
// assertion macros for the date adder checks
// no dependencies; taken in by the top level with an include
`ifndef GREGORIAN_DATE_ADD_DAYS_ASSERT_SVH
`define GREGORIAN_DATE_ADD_DAYS_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication under reset
`define GDAD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under reset
`define GDAD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define GDAD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)

`define GDAD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> rtl/gdad_pkg.sv
// shared types and constants for the gregorian date adder
// no dependencies
package gdad_pkg;

    localparam int DayW        = 5;
    localparam int MonthW      = 4;
    localparam int YearW       = 14;
    localparam int StatusW     = 2;
    localparam int AddFieldW   = 16;
    localparam int AddWidthDef = 16;
    localparam int CentW       = 7;

    // reciprocal of 100: floor(y * 5243 / 2^19) is exact for any 14-bit year
    localparam int RecipW     = 13;
    localparam int RecipShift = 19;
    localparam int ProdW      = YearW + RecipW;
    localparam int QuotW      = ProdW - RecipShift;
    localparam logic [RecipW-1:0] RecipMul = 13'd5243;

    localparam logic [YearW-1:0]  MaxYear     = 14'd9999;
    localparam logic [YearW-1:0]  MinYearExcl = 14'd1600;
    localparam logic [YearW-1:0]  CenturyLen  = 14'd100;
    localparam logic [CentW-1:0]  CentLast    = 7'd99;
    localparam logic [MonthW-1:0] MonthJan    = 4'd1;
    localparam logic [MonthW-1:0] MonthFeb    = 4'd2;
    localparam logic [MonthW-1:0] MonthDec    = 4'd12;
    localparam logic [DayW-1:0]   DayLast     = 5'd31;
    localparam logic [DayW-1:0]   LeapFebLen  = 5'd29;

    // standard month lengths, january first
    localparam logic [DayW-1:0] MonthDays [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef struct packed {
        logic div4;
        logic cent;
        logic div400;
    } t_leap;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_REM,
        S_CHECK,
        S_LOOP
    } t_state;

endpackage

>>> rtl/gdad_if.sv
// valid/ready channels for the date adder: start date in, result date out
// depends on gdad_pkg for field widths
interface gdad_in_if;
    logic                           valid;
    logic                           ready;
    logic [gdad_pkg::DayW-1:0]      start_day;
    logic [gdad_pkg::MonthW-1:0]    start_month;
    logic [gdad_pkg::YearW-1:0]     start_year;
    logic [gdad_pkg::AddFieldW-1:0] days_to_add;

    modport source (output valid, start_day, start_month, start_year, days_to_add,
                    input ready);
    modport sink   (input valid, start_day, start_month, start_year, days_to_add,
                    output ready);
endinterface

interface gdad_out_if;
    logic                         valid;
    logic                         ready;
    logic [gdad_pkg::DayW-1:0]    result_day;
    logic [gdad_pkg::MonthW-1:0]  result_month;
    logic [gdad_pkg::YearW-1:0]   result_year;
    logic [gdad_pkg::StatusW-1:0] status;

    modport source (output valid, result_day, result_month, result_year, status,
                    input ready);
    modport sink   (input valid, result_day, result_month, result_year, status,
                    output ready);
endinterface

>>> rtl/gdad_month_len.sv
// month length lookup with the gregorian leap rule
// depends on gdad_pkg (month table, leap flags)
module gdad_month_len (
    input  logic [gdad_pkg::MonthW-1:0] i_month,
    input  gdad_pkg::t_leap             i_leap,
    output logic [gdad_pkg::DayW-1:0]   o_len
);

    logic w_leap;

    // leap: divisible by 4 and not by 100, or divisible by 400
    assign w_leap = (i_leap.div4 && !i_leap.cent) || i_leap.div400;

    // out-of-range months have length zero
    always_comb begin
        if (i_month == '0 || i_month > gdad_pkg::MonthDec) begin
            o_len = '0;
        end else if (i_month == gdad_pkg::MonthFeb && w_leap) begin
            o_len = gdad_pkg::LeapFebLen;
        end else begin
            o_len = gdad_pkg::MonthDays[i_month - gdad_pkg::MonthJan];
        end
    end

endmodule

>>> rtl/gregorian_date_add_days.sv
// gregorian date adder top level: sequencer around one subtract/compare unit
// depends on gdad_pkg, gdad_if, gdad_month_len and the assertion header
//
//  channel | dir | payload                                          | transfer
//  i_in    | in  | start_day, start_month, start_year, days_to_add  | valid && ready
//  o_out   | out | result_day, result_month, result_year, status    | valid && ready
//
// an item is accepted in S_IDLE, split into year mod 100 and century mod 4 in S_REM,
// checked and given its day count in S_CHECK, then walked one month at a time in S_LOOP
// through the single subtract/compare unit until the date settles or the year overflows
// i_in.ready is high only while the sequencer is idle; a finished result waits
// in the output register and the next item may be taken meanwhile
// synchronous active-low reset clears the sequencer and the output valid
`include "gregorian_date_add_days_assert.svh"

module gregorian_date_add_days #(
    parameter int ADD_WIDTH = gdad_pkg::AddWidthDef
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gdad_in_if.sink    i_in,
    gdad_out_if.source o_out
);

    localparam int DW   = ADD_WIDTH + 1;
    localparam int ExtW = (ADD_WIDTH > gdad_pkg::AddFieldW) ? ADD_WIDTH : gdad_pkg::AddFieldW;

    gdad_pkg::t_state r_state, n_state;

    logic [DW-1:0]                    r_day, n_day;
    logic [gdad_pkg::MonthW-1:0]      r_month, n_month;
    logic [gdad_pkg::YearW-1:0]       r_year, n_year;
    logic [ADD_WIDTH-1:0]             r_add, n_add;
    logic [gdad_pkg::ProdW-1:0]       r_prod, n_prod;
    logic [gdad_pkg::CentW-1:0]       r_r100, n_r100;
    logic [1:0]                       r_q2, n_q2;

    logic                             r_out_valid, n_out_valid;
    logic [gdad_pkg::DayW-1:0]        r_out_day, n_out_day;
    logic [gdad_pkg::MonthW-1:0]      r_out_month, n_out_month;
    logic [gdad_pkg::YearW-1:0]       r_out_year, n_out_year;
    logic [gdad_pkg::StatusW-1:0]     r_out_status, n_out_status;

    logic [ExtW-1:0]                  w_add_ext;
    logic [ADD_WIDTH-1:0]             w_add;
    logic [gdad_pkg::QuotW-1:0]       w_quot;
    logic [gdad_pkg::YearW-1:0]       w_cent_base;
    gdad_pkg::t_leap                  w_leap;
    logic [gdad_pkg::DayW-1:0]        w_len;
    logic [DW-1:0]                    w_len_ext;
    logic                             w_out_free;

    // only the low ADD_WIDTH bits of the count take part
    assign w_add_ext = ExtW'(i_in.days_to_add);
    assign w_add     = w_add_ext[ADD_WIDTH-1:0];

    // year split: quotient by 100 from the registered reciprocal product
    assign w_quot      = r_prod[gdad_pkg::ProdW-1:gdad_pkg::RecipShift];
    assign w_cent_base = gdad_pkg::YearW'(w_quot) * gdad_pkg::CenturyLen;

    // leap flags of the current year
    assign w_leap.div4   = (r_year[1:0] == 2'b00);
    assign w_leap.cent   = (r_r100 == '0);
    assign w_leap.div400 = (r_r100 == '0) && (r_q2 == 2'b00);

    gdad_month_len u_month_len (
        .i_month (r_month),
        .i_leap  (w_leap),
        .o_len   (w_len)
    );

    assign w_len_ext  = DW'(w_len);
    assign w_out_free = !r_out_valid || o_out.ready;

    // output channel
    assign o_out.valid        = r_out_valid;
    assign o_out.result_day   = r_out_day;
    assign o_out.result_month = r_out_month;
    assign o_out.result_year  = r_out_year;
    assign o_out.status       = r_out_status;

    // sequencer: next state and datapath
    always_comb begin
        n_state      = r_state;
        n_day        = r_day;
        n_month      = r_month;
        n_year       = r_year;
        n_add        = r_add;
        n_prod       = r_prod;
        n_r100       = r_r100;
        n_q2         = r_q2;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_day    = r_out_day;
        n_out_month  = r_out_month;
        n_out_year   = r_out_year;
        n_out_status = r_out_status;
        i_in.ready   = 1'b0;

        unique case (r_state)
            gdad_pkg::S_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    n_day   = DW'(i_in.start_day);
                    n_month = i_in.start_month;
                    n_year  = i_in.start_year;
                    n_add   = w_add;
                    n_prod  = gdad_pkg::ProdW'(i_in.start_year)
                            * gdad_pkg::ProdW'(gdad_pkg::RecipMul);
                    n_state = gdad_pkg::S_REM;
                end
            end
            gdad_pkg::S_REM: begin
                // year mod 100 and century mod 4
                n_r100  = gdad_pkg::CentW'(r_year - w_cent_base);
                n_q2    = w_quot[1:0];
                n_state = gdad_pkg::S_CHECK;
            end
            gdad_pkg::S_CHECK: begin
                if (r_day != '0 && r_day <= w_len_ext && r_year > gdad_pkg::MinYearExcl) begin
                    n_day   = r_day + DW'(r_add);
                    n_state = gdad_pkg::S_LOOP;
                end else if (w_out_free) begin
                    // invalid start date is echoed
                    n_out_valid  = 1'b1;
                    n_out_day    = r_day[gdad_pkg::DayW-1:0];
                    n_out_month  = r_month;
                    n_out_year   = r_year;
                    n_out_status = gdad_pkg::ST_INVALID;
                    n_state      = gdad_pkg::S_IDLE;
                end
            end
            gdad_pkg::S_LOOP: begin
                priority if (r_year > gdad_pkg::MaxYear) begin
                    // saturate to the last representable date
                    if (w_out_free) begin
                        n_out_valid  = 1'b1;
                        n_out_day    = gdad_pkg::DayLast;
                        n_out_month  = gdad_pkg::MonthDec;
                        n_out_year   = gdad_pkg::MaxYear;
                        n_out_status = gdad_pkg::ST_OVERFLOW;
                        n_state      = gdad_pkg::S_IDLE;
                    end
                end else if (r_day > w_len_ext) begin
                    // take off one month and advance
                    n_day = r_day - w_len_ext;
                    if (r_month == gdad_pkg::MonthDec) begin
                        n_month = gdad_pkg::MonthJan;
                        n_year  = r_year + 1'b1;
                        if (r_r100 == gdad_pkg::CentLast) begin
                            n_r100 = '0;
                            n_q2   = r_q2 + 1'b1;
                        end else begin
                            n_r100 = r_r100 + 1'b1;
                        end
                    end else begin
                        n_month = r_month + 1'b1;
                    end
                end else begin
                    // date settled, hand it over once the output is free
                    if (w_out_free) begin
                        n_out_valid  = 1'b1;
                        n_out_day    = r_day[gdad_pkg::DayW-1:0];
                        n_out_month  = r_month;
                        n_out_year   = r_year;
                        n_out_status = gdad_pkg::ST_OK;
                        n_state      = gdad_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = gdad_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gdad_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath and result registers
    always_ff @(posedge i_clk) begin
        r_day        <= n_day;
        r_month      <= n_month;
        r_year       <= n_year;
        r_add        <= n_add;
        r_prod       <= n_prod;
        r_r100       <= n_r100;
        r_q2         <= n_q2;
        r_out_day    <= n_out_day;
        r_out_month  <= n_out_month;
        r_out_year   <= n_out_year;
        r_out_status <= n_out_status;
    end

    // checks
    `GDAD_ASSERT_NXT(a_accept_starts, i_clk, i_rst_n,
        i_in.valid && i_in.ready,
        r_state == gdad_pkg::S_REM,
        "accepted item did not start the year split")
    `GDAD_ASSERT_IMP(a_loop_month, i_clk, i_rst_n,
        r_state == gdad_pkg::S_LOOP,
        r_month >= gdad_pkg::MonthJan && r_month <= gdad_pkg::MonthDec,
        "month out of range in the month loop")
    `GDAD_ASSERT_IMP(a_sat_date, i_clk, i_rst_n,
        r_out_valid && r_out_status == gdad_pkg::ST_OVERFLOW,
        r_out_year == gdad_pkg::MaxYear && r_out_month == gdad_pkg::MonthDec
            && r_out_day == gdad_pkg::DayLast,
        "saturated result is not the last date")
    `GDAD_ASSERT_IMP(a_ok_range, i_clk, i_rst_n,
        r_out_valid && r_out_status == gdad_pkg::ST_OK,
        r_out_day != '0 && r_out_year <= gdad_pkg::MaxYear
            && r_out_year > gdad_pkg::MinYearExcl,
        "ok result outside the valid date range")

endmodule
